// ===== hdl/positional_insert_delete_array_macros.svh =====
// assertion macros for the positional insert/delete array
// used by the top level only; expects clk and rst_n in scope
`ifndef POSITIONAL_INSERT_DELETE_ARRAY_MACROS_SVH
`define POSITIONAL_INSERT_DELETE_ARRAY_MACROS_SVH

// same-cycle implication, disabled during reset
`define PIDA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pida assertion failed");

// next-cycle implication, disabled during reset
`define PIDA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pida assertion failed");

`endif

// ===== hdl/pida_pkg.sv =====
// shared types and codes for the positional insert/delete array
// no dependencies; used by the sequencer, the top level and the testbench
package pida_pkg;

  // operation codes carried in func
  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_APPEND = 3'd1,
    OP_INSERT = 3'd2,
    OP_DELETE = 3'd3,
    OP_READ   = 3'd4
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_INS,
    S_INSW,
    S_DEL0,
    S_DEL,
    S_DONE
  } state_t;

  // finished result handed from the sequencer to the output register
  typedef struct packed {
    logic [31:0] data;
    logic [5:0]  count;
    status_t     status;
  } res_t;

endpackage

// ===== hdl/pida_if.sv =====
// valid/ready channel interfaces for requests and results
// no dependencies
interface pida_in_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  func;
  logic        [4:0]  position;
  logic signed [31:0] value;

  modport source (output valid, func, position, value, input ready);
  modport sink   (input valid, func, position, value, output ready);
endinterface

interface pida_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] data;
  logic        [5:0]  count;
  logic        [1:0]  status;

  modport source (output valid, data, count, status, input ready);
  modport sink   (input valid, data, count, status, output ready);
endinterface

// ===== hdl/pida_ram.sv =====
// generic single-write, single-read synchronous ram with registered read
// no dependencies
module pida_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ===== hdl/pida_ctrl.sv =====
// sequencer: decodes requests, keeps the length and walks the entry ram
// depends on pida_pkg
module pida_ctrl #(
  parameter int CAPACITY = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    in_func,
  input  logic [4:0]                    in_position,
  input  logic [31:0]                   in_value,
  input  logic                          slot_free,
  output logic                          res_valid,
  output pida_pkg::res_t                res,
  output logic                          mem_we,
  output logic [$clog2(CAPACITY)-1:0]   mem_waddr,
  output logic [31:0]                   mem_wdata,
  output logic [$clog2(CAPACITY)-1:0]   mem_raddr,
  input  logic [31:0]                   mem_rdata
);

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int CW = (LW > 5) ? LW : 5;
  localparam int KW = (LW > 6) ? LW : 6;

  pida_pkg::state_t  state_r, state_nxt;
  logic [LW-1:0]     len_r, len_nxt;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic [31:0]       val_r, val_nxt;
  logic [31:0]       data_r, data_nxt;
  pida_pkg::status_t status_r, status_nxt;

  logic [CW-1:0] pos_x;
  logic [CW-1:0] len_x;
  logic [AW-1:0] pos_idx;
  logic [AW-1:0] len_idx;
  logic          full;
  logic          empty;
  logic          more;
  logic [KW-1:0] cnt_ext;

  // request decode helpers
  assign pos_x   = CW'(in_position);
  assign len_x   = CW'(len_r);
  assign pos_idx = pos_x[AW-1:0];
  assign len_idx = len_r[AW-1:0];
  assign full    = (len_r == LW'(CAPACITY));
  assign empty   = (len_r == '0);
  // another entry above the one just read still has to move down
  assign more    = ((LW'(addr_r) + LW'(1)) < len_r);

  // result as seen by the output register
  assign cnt_ext    = KW'(len_r);
  assign res.data   = data_r;
  assign res.count  = cnt_ext[5:0];
  assign res.status = status_r;

  // state and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pida_pkg::S_IDLE;
      len_r   <= '0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
    end
    addr_r   <= addr_nxt;
    pos_r    <= pos_nxt;
    val_r    <= val_nxt;
    data_r   <= data_nxt;
    status_r <= status_nxt;
  end

  // next state, memory accesses and result
  always_comb begin
    state_nxt  = state_r;
    len_nxt    = len_r;
    addr_nxt   = addr_r;
    pos_nxt    = pos_r;
    val_nxt    = val_r;
    data_nxt   = data_r;
    status_nxt = status_r;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = addr_r;
    mem_wdata  = mem_rdata;
    mem_raddr  = addr_r;

    unique case (state_r)
      pida_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          data_nxt   = '0;
          status_nxt = pida_pkg::ST_OK;
          state_nxt  = pida_pkg::S_DONE;
          pos_nxt    = pos_idx;
          val_nxt    = in_value;
          unique case (in_func)
            pida_pkg::OP_CLEAR: begin
              len_nxt = '0;
            end
            pida_pkg::OP_APPEND: begin
              if (full) begin
                status_nxt = pida_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = len_idx;
                mem_wdata = in_value;
                len_nxt   = len_r + LW'(1);
              end
            end
            pida_pkg::OP_INSERT: begin
              priority if (full) begin
                status_nxt = pida_pkg::ST_FULL;
              end else if (pos_x > len_x) begin
                status_nxt = pida_pkg::ST_BADPOS;
              end else if (pos_x == len_x) begin
                mem_we    = 1'b1;
                mem_waddr = len_idx;
                mem_wdata = in_value;
                len_nxt   = len_r + LW'(1);
              end else begin
                // start moving the top entry up
                mem_raddr = len_idx - AW'(1);
                addr_nxt  = len_idx - AW'(1);
                state_nxt = pida_pkg::S_INS;
              end
            end
            pida_pkg::OP_DELETE: begin
              priority if (empty) begin
                status_nxt = pida_pkg::ST_EMPTY;
              end else if (pos_x >= len_x) begin
                status_nxt = pida_pkg::ST_BADPOS;
              end else begin
                mem_raddr = pos_idx;
                addr_nxt  = pos_idx;
                state_nxt = pida_pkg::S_DEL0;
              end
            end
            pida_pkg::OP_READ: begin
              priority if (empty) begin
                status_nxt = pida_pkg::ST_EMPTY;
              end else if (pos_x >= len_x) begin
                status_nxt = pida_pkg::ST_BADPOS;
              end else begin
                mem_raddr = pos_idx;
                state_nxt = pida_pkg::S_RD;
              end
            end
            default: begin
              // unknown operation answers ok and changes nothing
            end
          endcase
        end
      end

      // read data arrives
      pida_pkg::S_RD: begin
        data_nxt  = mem_rdata;
        state_nxt = pida_pkg::S_DONE;
      end

      // move entry addr_r up by one, walking down to the position
      pida_pkg::S_INS: begin
        mem_we    = 1'b1;
        mem_waddr = addr_r + AW'(1);
        mem_wdata = mem_rdata;
        if (addr_r == pos_r) begin
          state_nxt = pida_pkg::S_INSW;
        end else begin
          mem_raddr = addr_r - AW'(1);
          addr_nxt  = addr_r - AW'(1);
        end
      end

      // place the new value in the opened slot
      pida_pkg::S_INSW: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        mem_wdata = val_r;
        len_nxt   = len_r + LW'(1);
        state_nxt = pida_pkg::S_DONE;
      end

      // removed value arrives; start pulling later entries down
      pida_pkg::S_DEL0: begin
        data_nxt = mem_rdata;
        if (more) begin
          mem_raddr = addr_r + AW'(1);
          addr_nxt  = addr_r + AW'(1);
          state_nxt = pida_pkg::S_DEL;
        end else begin
          len_nxt   = len_r - LW'(1);
          state_nxt = pida_pkg::S_DONE;
        end
      end

      // move entry addr_r down by one
      pida_pkg::S_DEL: begin
        mem_we    = 1'b1;
        mem_waddr = addr_r - AW'(1);
        mem_wdata = mem_rdata;
        if (more) begin
          mem_raddr = addr_r + AW'(1);
          addr_nxt  = addr_r + AW'(1);
        end else begin
          len_nxt   = len_r - LW'(1);
          state_nxt = pida_pkg::S_DONE;
        end
      end

      // hand the result over once the output register has room
      pida_pkg::S_DONE: begin
        res_valid = slot_free;
        if (slot_free) begin
          state_nxt = pida_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = pida_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/positional_insert_delete_array.sv =====
// Positional insert/delete array: an ordered list of up to CAPACITY signed
// 32-bit values held in one synchronous ram, plus a length register.
//
// Channels: in_req carries a request (func, position, value) and out_rsp a
// result (data, count, status), both valid/ready. Each request gives one
// result. Clear, append, unknown codes and every failing request go from
// acceptance straight to the handover state; a read first takes the ram
// data, insert moves the entries from the top down to position p up by one
// and then writes the value, and delete moves the later entries down by
// one; the single ram port pair moves one entry per cycle. The sequencer
// returns to idle on handover and takes the next request in the cycle after.
// One request is worked on at a time; the next is accepted as soon as the
// sequencer is idle, even while the last result still sits in the output
// register. If the receiver stalls, a finished result waits in the
// sequencer until the output register frees up.
// Reset (synchronous, active low) empties the list at once; ram contents
// are not cleared and entries are only read after they are written.
// Depends on pida_pkg, pida_if, pida_ram, pida_ctrl and the macro header.
`include "positional_insert_delete_array_macros.svh"

module positional_insert_delete_array #(
  parameter int CAPACITY = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  pida_in_if.sink     in_req,
  pida_out_if.source  out_rsp
);

  localparam int AW = $clog2(CAPACITY);
  localparam logic [5:0] CAP_CNT = 6'(CAPACITY);

  logic           slot_free;
  logic           res_valid;
  pida_pkg::res_t res;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [31:0]    mem_wdata;
  logic [AW-1:0]  mem_raddr;
  logic [31:0]    mem_rdata;
  logic           in_fire;

  logic           out_valid_r;
  pida_pkg::res_t out_res_r;

  assign in_fire   = in_req.valid & in_req.ready;
  assign slot_free = !out_valid_r || out_rsp.ready;

  // entry store
  pida_ram #(
    .WIDTH (32),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // request sequencer
  pida_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_req.valid),
    .in_ready    (in_req.ready),
    .in_func     (in_req.func),
    .in_position (in_req.position),
    .in_value    (in_req.value),
    .slot_free   (slot_free),
    .res_valid   (res_valid),
    .res         (res),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_rsp.valid  = out_valid_r;
  assign out_rsp.data   = out_res_r.data;
  assign out_rsp.count  = out_res_r.count;
  assign out_rsp.status = out_res_r.status;

  // checks
  `PIDA_ASSERT_NEXT(a_busy_after_req, in_fire, !in_req.ready)
  `PIDA_ASSERT_IMPL(a_handover_has_room, res_valid, slot_free)
  `PIDA_ASSERT_IMPL(a_empty_has_no_count,
    out_rsp.valid && (out_rsp.status == pida_pkg::ST_EMPTY), out_rsp.count == 6'd0)
  `PIDA_ASSERT_IMPL(a_full_at_capacity,
    out_rsp.valid && (out_rsp.status == pida_pkg::ST_FULL), out_rsp.count == CAP_CNT)

endmodule

// ===== tb/sv/pida_list_checker.sv =====
// checker for the positional insert/delete array: mirrors the list, predicts
// each result and compares it with what the block returns
// depends on pida_pkg and the pida_in_if / pida_out_if interfaces
module pida_list_checker #(
  parameter int CAPACITY = 32
) (
  input  logic clk,
  input  logic rst_n,
  pida_in_if   in_req,
  pida_out_if  out_rsp,
  output int   mismatch_cnt,
  output int   outstanding,
  output int   results_cnt,
  output int   hits_ok,
  output int   hits_badpos,
  output int   hits_full,
  output int   hits_empty
);
  timeunit 1ns;
  timeprecision 1ps;
  import pida_pkg::*;

  // keep the log readable when the block is badly broken
  localparam int REPORT_CAP = 200;

  typedef struct {
    logic signed [31:0] data;
    logic [5:0]         count;
    status_t            status;
  } list_result_t;

  // mirror of the list held by the block
  logic signed [31:0] list_mem [CAPACITY];
  int                 list_len;
  list_result_t       pending_results [$];

  // apply one request to the mirror and return the result it should give
  function automatic list_result_t apply_list_op(logic [2:0] func, logic [4:0] pos,
                                                 logic signed [31:0] val);
    list_result_t r;
    int k;
    r.data   = '0;
    r.status = ST_OK;
    case (func)
      OP_CLEAR: list_len = 0;
      OP_APPEND: begin
        if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          list_mem[list_len] = val;
          list_len++;
        end
      end
      OP_INSERT: begin
        if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (int'(pos) > list_len) begin
          r.status = ST_BADPOS;
        end else begin
          // open a hole at pos by moving the tail up
          for (k = list_len; k > int'(pos); k--) list_mem[k] = list_mem[k - 1];
          list_mem[pos] = val;
          list_len++;
        end
      end
      OP_DELETE: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else if (int'(pos) >= list_len) begin
          r.status = ST_BADPOS;
        end else begin
          // close the gap by moving the tail down
          r.data = list_mem[pos];
          for (k = int'(pos); k < list_len - 1; k++) list_mem[k] = list_mem[k + 1];
          list_len--;
        end
      end
      OP_READ: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else if (int'(pos) >= list_len) r.status = ST_BADPOS;
        else r.data = list_mem[pos];
      end
      default: ;
    endcase
    r.count = 6'(list_len);
    return r;
  endfunction

  task automatic flag_field(string field, logic signed [31:0] want_v,
                            logic signed [31:0] got_v);
    mismatch_cnt++;
    if (mismatch_cnt <= REPORT_CAP)
      $error("%s mismatch: expected %0d, got %0d", field, want_v, got_v);
  endtask

  initial begin
    mismatch_cnt = 0;
    outstanding  = 0;
    results_cnt  = 0;
    hits_ok      = 0;
    hits_badpos  = 0;
    hits_full    = 0;
    hits_empty   = 0;
    list_len     = 0;
  end

  // compare results first, then queue the request accepted on the same edge
  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      pending_results.delete();
      list_len = 0;
    end else begin
      if (out_rsp.valid && out_rsp.ready) begin
        results_cnt++;
        if (pending_results.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_CAP)
            $error("result with no request waiting: data %0d count %0d status %0d",
                   out_rsp.data, out_rsp.count, out_rsp.status);
        end else begin
          want = pending_results.pop_front();
          if (out_rsp.data !== want.data) flag_field("data", want.data, out_rsp.data);
          if (out_rsp.count !== want.count) flag_field("count", want.count, out_rsp.count);
          if (out_rsp.status !== want.status)
            flag_field("status", want.status, out_rsp.status);
          case (want.status)
            ST_OK:     hits_ok++;
            ST_BADPOS: hits_badpos++;
            ST_FULL:   hits_full++;
            ST_EMPTY:  hits_empty++;
            default: ;
          endcase
        end
      end
      if (in_req.valid && in_req.ready)
        pending_results.push_back(apply_list_op(in_req.func, in_req.position,
                                                in_req.value));
    end
    outstanding = pending_results.size();
  end

endmodule

// ===== tb/sv/tb_positional_insert_delete_array.sv =====
// top of the positional insert/delete array testbench: clock, reset, request
// stimulus, result back-pressure, watchdog and verdict
// depends on pida_pkg, pida_if, the block itself and pida_list_checker
module tb_positional_insert_delete_array;
  timeunit 1ns;
  timeprecision 1ps;
  import pida_pkg::*;

  localparam int CAPACITY     = 32;
  localparam int TOTAL_REQS   = 1800;
  localparam int QUIET_TAIL   = 250;
  localparam int HOLD_AT      = 600;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = CAPACITY + 8;
  localparam int STALL_LIMIT  = 2000;

  // func codes the block does not define
  localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

  logic clk;
  logic rst_n;
  int   sent_cnt;
  int   shadow_len;
  int   quiet_cycles = 0;

  int mismatch_cnt, outstanding, results_cnt;
  int hits_ok, hits_badpos, hits_full, hits_empty;

  pida_in_if  in_req ();
  pida_out_if out_rsp ();

  positional_insert_delete_array #(.CAPACITY(CAPACITY)) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  pida_list_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_req       (in_req),
    .out_rsp      (out_rsp),
    .mismatch_cnt (mismatch_cnt),
    .outstanding  (outstanding),
    .results_cnt  (results_cnt),
    .hits_ok      (hits_ok),
    .hits_badpos  (hits_badpos),
    .hits_full    (hits_full),
    .hits_empty   (hits_empty)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // no idling in the tail of the run and in every fourth stretch
  function automatic bit calm();
    return (sent_cnt >= TOTAL_REQS - QUIET_TAIL) || ((sent_cnt / 128) % 4 == 3);
  endfunction

  // position below limit, or anything when limit is zero
  function automatic logic [4:0] some_pos(int limit);
    if (limit <= 0) return 5'($urandom);
    return 5'($urandom_range(0, limit - 1));
  endfunction

  // mostly random values, with the extremes mixed in
  function automatic logic signed [31:0] some_value();
    case ($urandom_range(0, 15))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // offer one request, with an optional idle burst, and wait until taken
  task automatic send_req(logic [2:0] func, logic [4:0] pos, logic signed [31:0] val);
    int gap;
    gap = 0;
    if (!calm() && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.valid    <= 1'b1;
    in_req.func     <= func;
    in_req.position <= pos;
    in_req.value    <= val;
    do @(posedge clk); while (!in_req.ready);
    sent_cnt++;
    // follow the list length so later positions can be aimed
    case (func)
      OP_CLEAR:  shadow_len = 0;
      OP_APPEND: if (shadow_len < CAPACITY) shadow_len++;
      OP_INSERT: if (shadow_len < CAPACITY && int'(pos) <= shadow_len) shadow_len++;
      OP_DELETE: if (int'(pos) < shadow_len) shadow_len--;
      default: ;
    endcase
  endtask

  // fill the list up, then hit it a few times while full
  task automatic grow_list();
    while (shadow_len < CAPACITY && sent_cnt < TOTAL_REQS) begin
      if ($urandom_range(0, 1)) send_req(OP_APPEND, 5'($urandom), some_value());
      else send_req(OP_INSERT, some_pos(shadow_len + 1), some_value());
      if ($urandom_range(0, 4) == 0) send_req(OP_READ, some_pos(shadow_len), some_value());
    end
    repeat ($urandom_range(1, 3))
      send_req($urandom_range(0, 1) ? OP_APPEND : OP_INSERT, 5'($urandom), some_value());
  endtask

  // empty the list from random positions, then poke the empty list
  task automatic shrink_list();
    while (shadow_len > 0 && sent_cnt < TOTAL_REQS) begin
      send_req(OP_DELETE, some_pos(shadow_len), some_value());
      if (shadow_len > 0 && $urandom_range(0, 5) == 0)
        send_req(OP_READ, some_pos(shadow_len), some_value());
    end
    repeat ($urandom_range(1, 2))
      send_req($urandom_range(0, 1) ? OP_DELETE : OP_READ, 5'($urandom), some_value());
  endtask

  // mostly well-aimed reads, inserts and deletes, with some noise
  task automatic mixed_ops(int n);
    int sel;
    repeat (n) begin
      sel = $urandom_range(0, 19);
      if (sel < 6) begin
        send_req(OP_READ, some_pos(shadow_len), some_value());
      end else if (sel < 10) begin
        send_req(OP_INSERT, some_pos((shadow_len < CAPACITY) ? shadow_len + 1 : CAPACITY),
                 some_value());
      end else if (sel < 14) begin
        send_req(OP_DELETE, some_pos(shadow_len), some_value());
      end else if (sel < 16) begin
        send_req(OP_APPEND, 5'($urandom), some_value());
      end else if (sel < 19) begin
        send_req(3'($urandom_range(OP_APPEND, OP_READ)), 5'($urandom), some_value());
      end else if ($urandom_range(0, 3) == 0) begin
        send_req(OP_CLEAR, 5'($urandom), some_value());
      end else begin
        send_req(3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI)), 5'($urandom),
                 some_value());
      end
    end
  endtask

  // result side: short random stalls, one long hold to back the block up
  initial begin
    int  stall_left;
    bit  hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    out_rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && sent_cnt >= HOLD_AT) begin
        hold_done  = 1'b1;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && !calm() && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 4);
      end
      if (stall_left > 0) begin
        out_rsp.ready <= 1'b0;
        stall_left--;
      end else begin
        out_rsp.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if (!rst_n || (in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // stimulus and verdict
  initial begin
    sent_cnt   = 0;
    shadow_len = 0;
    rst_n           <= 1'b0;
    in_req.valid    <= 1'b0;
    in_req.func     <= OP_CLEAR;
    in_req.position <= '0;
    in_req.value    <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty list: empty status even at a bad position, spare code is a no-op
    send_req(OP_READ, 5'd0, 32'sd0);
    send_req(OP_DELETE, 5'd31, 32'sd0);
    send_req(FUNC_SPARE_LO, 5'd0, 32'sd0);
    // build [-1, min, 5555_5555, max, 0] through front, end, middle and bad-position inserts
    send_req(OP_APPEND, 5'd0, 32'h8000_0000);
    send_req(OP_APPEND, 5'd31, 32'h7fff_ffff);
    send_req(OP_INSERT, 5'd0, -32'sd1);
    send_req(OP_INSERT, 5'd3, 32'sd0);
    send_req(OP_INSERT, 5'd5, 32'sd7);
    send_req(OP_INSERT, 5'd31, 32'sd7);
    send_req(OP_INSERT, 5'd2, 32'h5555_5555);
    for (int i = 0; i < 5; i++) send_req(OP_READ, 5'(i), 32'sd0);
    // reads and deletes just past the end and far out
    send_req(OP_READ, 5'd5, 32'sd0);
    send_req(OP_READ, 5'd31, 32'sd0);
    send_req(OP_DELETE, 5'd31, 32'sd0);
    send_req(OP_DELETE, 5'd5, 32'sd0);
    // delete from the middle, the end and the front
    send_req(OP_DELETE, 5'd2, 32'sd0);
    send_req(OP_DELETE, 5'd3, 32'sd0);
    send_req(OP_DELETE, 5'd0, 32'sd0);
    send_req(FUNC_SPARE_LO, 5'd31, 32'h7fff_ffff);
    send_req(FUNC_SPARE_HI, 5'd0, 32'h8000_0000);
    send_req(OP_CLEAR, 5'd0, 32'sd0);
    send_req(OP_READ, 5'd0, 32'sd0);

    // random episodes of growth, drain, mixed traffic and clears
    while (sent_cnt < TOTAL_REQS) begin
      case ($urandom_range(0, 9))
        0, 1, 2: grow_list();
        3, 4:    shrink_list();
        9:       send_req(OP_CLEAR, 5'($urandom), some_value());
        default: mixed_ops($urandom_range(10, 40));
      endcase
    end
    in_req.valid <= 1'b0;

    do @(negedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests and %0d results in insert/delete/read/clear traffic",
             sent_cnt, results_cnt);
    $display("status mix: ok %0d, bad position %0d, full %0d, empty %0d",
             hits_ok, hits_badpos, hits_full, hits_empty);
    if (outstanding != 0) $error("%0d expected results never arrived", outstanding);
    if (mismatch_cnt == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== positional_insert_delete_array.f =====
+incdir+hdl
hdl/pida_pkg.sv
hdl/pida_if.sv
hdl/pida_ram.sv
hdl/pida_ctrl.sv
hdl/positional_insert_delete_array.sv
tb/sv/pida_list_checker.sv
tb/sv/tb_positional_insert_delete_array.sv
